[hdl/olt_pkg.sv]
// shared constants, command/status codes and types for the ordered list table
// no dependencies; compiled first
package olt_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int IDX_W  = 16;
  localparam int STEP_W = $clog2(IDX_W);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_GET,
    S_FIND,
    S_REM,
    S_RESP
  } state_t;

  // request to the index wrap unit
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] len;
  } wrap_req_t;

endpackage

[hdl/olt_req_if.sv]
// request channel: command and operands, valid/ready handshake
// depends on olt_pkg
interface olt_req_if import olt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cmd_t                    command;
  logic signed [IDX_W-1:0] index;
  logic [DATA_W-1:0]       value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

[hdl/olt_rsp_if.sv]
// response channel: status, read data, position and entry count
// depends on olt_pkg
interface olt_rsp_if import olt_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [DATA_W-1:0] read_value;
  logic [ADDR_W-1:0] position;
  logic [CNT_W-1:0]  count;

  modport source (output valid, status, read_value, position, count, input ready);
  modport sink   (input valid, status, read_value, position, count, output ready);
endinterface

[hdl/olt_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module olt_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/olt_wrap.sv]
// index wrap unit: signed index modulo list length, one quotient bit per cycle
// depends on olt_pkg
module olt_wrap import olt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  wrap_req_t         req,
  output logic              done,
  output logic [ADDR_W-1:0] pos
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  mag;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  len;
  logic              neg;
  logic [CNT_W:0]    shifted;
  logic [CNT_W-1:0]  rem_next;
  logic [CNT_W-1:0]  wrapped;

  // restoring remainder step
  always_comb begin
    shifted = {rem, mag[IDX_W-1]};
    if (shifted >= {1'b0, len}) begin
      rem_next = CNT_W'(shifted - {1'b0, len});
    end else begin
      rem_next = shifted[CNT_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == STEP_W'(IDX_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(IDX_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: magnitude of the index and running remainder
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= req.index[IDX_W-1];
      mag <= req.index[IDX_W-1] ? (~req.index + 1'b1) : req.index;
      len <= req.len;
      rem <= '0;
    end else if (busy) begin
      mag <= {mag[IDX_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // negative index counts back from the end; an exact multiple wraps to 0
  assign wrapped = (neg && (rem != '0)) ? (len - rem) : rem;
  assign pos     = wrapped[ADDR_W-1:0];

endmodule

[hdl/ordered_list_table_core.sv]
// ordered list table: top level with sequencer, entry memory and wrap unit
// depends on olt_pkg, olt_req_if, olt_rsp_if, olt_ram, olt_wrap
//
// Fixed-capacity ordered list of DEPTH entries held in one block ram.
// The req channel carries a command (add, get, find, remove) with index and
// value; every transfer on req produces exactly one transfer on rsp with
// status, read value, position and the entry count after the command.
// Commands run one at a time; req is ready only while the sequencer is idle.
// Add, and get, remove or find on an empty list, load the result at once and
// go to the response state. Get runs the 16-step index wrap unit, then one
// ram read. Find reads from slot 0 up to the first match, or through every
// entry on a miss. Remove runs the wrap unit, then moves each entry above the
// wrapped index down one slot (length - 1 - wrapped index entries, maybe none).
// Find and remove are bounded by the single ram read port, one entry a cycle.
// The result sits in an output register: when rsp is stalled, the next
// request is still accepted and runs, and only its own result waits.
// Reset empties the list; entry contents need no clearing since only slots
// below the count are ever read.
module ordered_list_table_core import olt_pkg::*; (
  input logic      clk,
  input logic      rst,
  olt_req_if.sink  req,
  olt_rsp_if.source rsp
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  len, len_next;
  cmd_t              cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [ADDR_W-1:0] pos_r;
  logic [CNT_W-1:0]  rd_k;
  logic [CNT_W-1:0]  cmp_k;
  logic              rv;
  logic              issue;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              wrap_start;
  wrap_req_t         wrap_req;
  logic              wrap_done;
  logic [ADDR_W-1:0] wrap_pos;

  logic              res_load;
  status_t           res_status_d, res_status;
  logic [DATA_W-1:0] res_value_d, res_value;
  logic [ADDR_W-1:0] res_pos_d, res_pos;

  logic              out_load;
  logic              out_valid;
  status_t           o_status;
  logic [DATA_W-1:0] o_value;
  logic [ADDR_W-1:0] o_pos;
  logic [CNT_W-1:0]  o_count;

  olt_ram #(.W(DATA_W), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign wrap_req.index = req.index;
  assign wrap_req.len   = len;

  olt_wrap u_wrap (
    .clk   (clk),
    .rst   (rst),
    .start (wrap_start),
    .req   (wrap_req),
    .done  (wrap_done),
    .pos   (wrap_pos)
  );

  assign req.ready = (state == S_IDLE);
  assign issue     = (rd_k < len);

  // next state, ram controls and result selection
  always_comb begin
    state_next   = state;
    len_next     = len;
    ram_we       = 1'b0;
    ram_waddr    = len[ADDR_W-1:0];
    ram_wdata    = req.value;
    ram_raddr    = rd_k[ADDR_W-1:0];
    wrap_start   = 1'b0;
    res_load     = 1'b0;
    res_status_d = ST_OK;
    res_value_d  = '0;
    res_pos_d    = '0;
    out_load     = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.command)
            CMD_ADD: begin
              res_load   = 1'b1;
              state_next = S_RESP;
              if (len == CNT_W'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                res_pos_d = len[ADDR_W-1:0];
                len_next  = len + 1'b1;
              end
            end
            CMD_GET, CMD_REMOVE: begin
              if (len == '0) begin
                res_load     = 1'b1;
                res_status_d = ST_EMPTY;
                state_next   = S_RESP;
              end else begin
                wrap_start = 1'b1;
                state_next = S_WRAP;
              end
            end
            CMD_FIND: begin
              if (len == '0) begin
                res_load     = 1'b1;
                res_status_d = ST_MISSING;
                state_next   = S_RESP;
              end else begin
                state_next = S_FIND;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_WRAP: begin
        if (wrap_done) begin
          ram_raddr  = wrap_pos;
          state_next = (cmd_r == CMD_GET) ? S_GET : S_REM;
        end
      end
      S_GET: begin
        res_load    = 1'b1;
        res_value_d = ram_rdata;
        res_pos_d   = pos_r;
        state_next  = S_RESP;
      end
      S_FIND: begin
        // reads are pipelined: data for slot cmp_k arrives while rd_k is issued
        if (rv && (ram_rdata == val_r)) begin
          res_load   = 1'b1;
          res_pos_d  = cmp_k[ADDR_W-1:0];
          state_next = S_RESP;
        end else if (rv && (cmp_k == len - 1'b1)) begin
          res_load     = 1'b1;
          res_status_d = ST_MISSING;
          state_next   = S_RESP;
        end
      end
      S_REM: begin
        // move the entry read last cycle down by one slot
        if (rv) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_k[ADDR_W-1:0] - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (!issue && !rv) begin
          res_load   = 1'b1;
          res_pos_d  = pos_r;
          len_next   = len - 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      rv    <= ((state == S_FIND) || (state == S_REM)) && issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and scan counters
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req.valid) begin
      cmd_r <= req.command;
      val_r <= req.value;
    end
    cmp_k <= rd_k;
    if (state == S_IDLE) begin
      rd_k <= '0;
    end else if ((state == S_WRAP) && wrap_done) begin
      pos_r <= wrap_pos;
      rd_k  <= {1'b0, wrap_pos} + 1'b1;
    end else if (((state == S_FIND) || (state == S_REM)) && issue) begin
      rd_k <= rd_k + 1'b1;
    end
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_d;
      res_value  <= res_value_d;
      res_pos    <= res_pos_d;
    end
    if (out_load) begin
      o_status <= res_status;
      o_value  <= res_value;
      o_pos    <= res_pos;
      o_count  <= len;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = o_status;
  assign rsp.read_value = o_value;
  assign rsp.position   = o_pos;
  assign rsp.count      = o_count;

endmodule

[hdl/olt_checker.sv]
// port-level checks on the response channel of the ordered list table
// depends on olt_pkg; bound to ordered_list_table_core
module olt_checker import olt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input status_t           status,
  input logic [DATA_W-1:0] read_value,
  input logic [ADDR_W-1:0] position,
  input logic [CNT_W-1:0]  count
);

  // a stalled response holds its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(read_value)
      && $stable(position) && $stable(count))
    else $error("response changed while stalled");

  // count never exceeds capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> count <= CNT_W'(DEPTH))
    else $error("count above capacity");

  // failed commands report zero data and position
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (read_value == '0) && (position == '0))
    else $error("nonzero data on failed command");

  // full and empty reports agree with the count
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> count == CNT_W'(DEPTH))
    else $error("full reported below capacity");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> count == '0)
    else $error("empty reported with entries present");

endmodule

bind ordered_list_table_core olt_checker u_olt_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .read_value (rsp.read_value),
  .position   (rsp.position),
  .count      (rsp.count)
);

[dv/ordered_list_table_core_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for ordered_list_table_core: directed table, then random phases
// depends on olt_pkg, olt_req_if, olt_rsp_if and the core rtl
module ordered_list_table_core_tb;
  import olt_pkg::*;

  localparam int IDLE_PCT        = 34;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 300;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] read_value;
    logic [ADDR_W-1:0] position;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic              typed;
    list_result_t      want;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;

  olt_req_if req_if ();
  olt_rsp_if rsp_if ();

  ordered_list_table_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // shadow copy of the list contents and length
  logic [DATA_W-1:0] shadow_entries [DEPTH];
  int                shadow_len;

  list_result_t pending_results [$];
  int           mismatch_count;
  int           stall_cycles;
  bit           calm;
  bit           hold_rsp_request;

  // directed rows; typed rows carry an expectation read straight off the spec
  directed_row_t directed_rows [23] = '{
    '{CMD_GET,    16'h0000, 32'h0,        1'b1, '{ST_EMPTY,   32'h0,        8'd0, 9'd0}},
    '{CMD_REMOVE, 16'hFFFF, 32'h0,        1'b1, '{ST_EMPTY,   32'h0,        8'd0, 9'd0}},
    '{CMD_FIND,   16'h0000, 32'h0,        1'b1, '{ST_MISSING, 32'h0,        8'd0, 9'd0}},
    '{CMD_ADD,    16'h0000, 32'hFFFFFFFF, 1'b1, '{ST_OK,      32'h0,        8'd0, 9'd1}},
    '{CMD_ADD,    16'h0000, 32'h0,        1'b1, '{ST_OK,      32'h0,        8'd1, 9'd2}},
    '{CMD_ADD,    16'h0000, 32'hA5A55A5A, 1'b1, '{ST_OK,      32'h0,        8'd2, 9'd3}},
    '{CMD_ADD,    16'h0000, 32'hFFFFFFFF, 1'b1, '{ST_OK,      32'h0,        8'd3, 9'd4}},
    '{CMD_GET,    16'hFFFF, 32'h0,        1'b1, '{ST_OK,      32'hFFFFFFFF, 8'd3, 9'd4}},
    '{CMD_GET,    16'h8000, 32'h0,        1'b0, '0},
    '{CMD_GET,    16'h7FFF, 32'h0,        1'b0, '0},
    '{CMD_GET,    16'hFFFC, 32'h0,        1'b1, '{ST_OK,      32'hFFFFFFFF, 8'd0, 9'd4}},
    '{CMD_GET,    16'h0006, 32'h0,        1'b0, '0},
    '{CMD_FIND,   16'h0000, 32'hFFFFFFFF, 1'b1, '{ST_OK,      32'h0,        8'd0, 9'd4}},
    '{CMD_FIND,   16'h0000, 32'h0,        1'b0, '0},
    '{CMD_FIND,   16'h0000, 32'h12345678, 1'b1, '{ST_MISSING, 32'h0,        8'd0, 9'd4}},
    '{CMD_REMOVE, 16'h0001, 32'h0,        1'b0, '0},
    '{CMD_REMOVE, 16'hFFFF, 32'h0,        1'b0, '0},
    '{CMD_REMOVE, 16'h8000, 32'h0,        1'b0, '0},
    '{CMD_REMOVE, 16'h7FFF, 32'h0,        1'b0, '0},
    '{CMD_GET,    16'h0005, 32'h0,        1'b1, '{ST_EMPTY,   32'h0,        8'd0, 9'd0}},
    '{CMD_ADD,    16'h0000, 32'h00000001, 1'b1, '{ST_OK,      32'h0,        8'd0, 9'd1}},
    '{CMD_GET,    16'h8000, 32'h0,        1'b0, '0},
    '{CMD_REMOVE, 16'h0000, 32'h0,        1'b1, '{ST_OK,      32'h0,        8'd0, 9'd0}}
  };

  // signed index modulo length, negative multiples land on 0
  function automatic int wrap_position(input logic signed [IDX_W-1:0] idx, input int len);
    int mag;
    int rem;
    mag = (idx < 0) ? -int'(idx) : int'(idx);
    rem = mag % len;
    return (idx < 0 && rem != 0) ? len - rem : rem;
  endfunction

  // applies one command to the shadow list and returns its result
  function automatic list_result_t apply_list_command(input cmd_t cmd,
                                                      input logic signed [IDX_W-1:0] idx,
                                                      input logic [DATA_W-1:0] val);
    list_result_t res;
    int pos;
    bit found;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_ADD: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          res.position = shadow_len[ADDR_W-1:0];
          shadow_entries[shadow_len[ADDR_W-1:0]] = val;
          shadow_len++;
        end
      end
      CMD_GET: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = wrap_position(idx, shadow_len);
          res.read_value = shadow_entries[pos[ADDR_W-1:0]];
          res.position = pos[ADDR_W-1:0];
        end
      end
      CMD_FIND: begin
        found = 1'b0;
        for (int k = 0; k < shadow_len && !found; k++) begin
          if (shadow_entries[k[ADDR_W-1:0]] == val) begin
            found = 1'b1;
            res.position = k[ADDR_W-1:0];
          end
        end
        if (!found) res.status = ST_MISSING;
      end
      default: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = wrap_position(idx, shadow_len);
          for (int k = pos; k + 1 < shadow_len; k++) begin
            shadow_entries[k[ADDR_W-1:0]] = shadow_entries[ADDR_W'(k + 1)];
          end
          shadow_len--;
          res.position = pos[ADDR_W-1:0];
        end
      end
    endcase
    res.count = shadow_len[CNT_W-1:0];
    return res;
  endfunction

  // offers one command, waits for its transfer and records the expected result
  task automatic issue_command(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] val, input logic typed,
                               input list_result_t want);
    list_result_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.index   <= idx;
    req_if.value   <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = apply_list_command(cmd, idx, val);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // random command with weights; remove takes what is left of 100
  task automatic send_random(input int w_add, input int w_get, input int w_find);
    int roll;
    int span;
    int k;
    cmd_t cmd;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] val;
    roll = $urandom_range(99);
    if (roll < w_add) cmd = CMD_ADD;
    else if (roll < w_add + w_get) cmd = CMD_GET;
    else if (roll < w_add + w_get + w_find) cmd = CMD_FIND;
    else cmd = CMD_REMOVE;
    // index: full range, near the length, negative multiples, extremes
    span = (shadow_len == 0) ? 1 : shadow_len;
    roll = $urandom_range(99);
    if (roll < 40) begin
      idx = IDX_W'($urandom);
    end else if (roll < 70) begin
      idx = IDX_W'($urandom_range(2 * span) - span);
    end else if (roll < 85) begin
      k = $urandom_range(32768 / span, 1);
      idx = IDX_W'(-(k * span));
    end else begin
      case ($urandom_range(3))
        0: idx = 16'h8000;
        1: idx = 16'h7FFF;
        2: idx = 16'hFFFF;
        default: idx = '0;
      endcase
    end
    // value: stored entries for find hits, a small pool for duplicates, or anything
    roll = $urandom_range(99);
    if (roll < 30 && shadow_len != 0) begin
      val = shadow_entries[ADDR_W'($urandom_range(shadow_len - 1))];
    end
    else if (roll < 50) val = $urandom_range(7);
    else if (roll < 55) val = '1;
    else val = $urandom;
    issue_command(cmd, idx, val, 1'b0, '0);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stimulus
  initial begin
    req_if.valid   = 1'b0;
    req_if.command = CMD_ADD;
    req_if.index   = '0;
    req_if.value   = '0;
    shadow_len     = 0;
    mismatch_count = 0;
    calm           = 1'b0;
    hold_rsp_request = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      issue_command(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].val,
                    directed_rows[r].typed, directed_rows[r].want);
    end

    // mixed traffic on a short list
    repeat (60) send_random(35, 25, 20);

    // pause the sender until every result is back
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // fill to capacity while the receiver holds off for a while
    hold_rsp_request = 1'b1;
    while (shadow_len < DEPTH) send_random(88, 4, 4);

    // full list, no idling on either side
    calm = 1'b1;
    repeat (60) send_random(35, 20, 35);
    calm = 1'b0;

    // drain to empty, then some traffic around empty
    while (shadow_len > 0) send_random(4, 3, 3);
    repeat (30) send_random(25, 25, 25);

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp_request) begin
        hold_rsp_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d read_value=%h position=%0d count=%0d",
                 $time, rsp_if.status, rsp_if.read_value, rsp_if.position, rsp_if.count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.read_value !== want.read_value ||
            rsp_if.position !== want.position || rsp_if.count !== want.count) begin
          $display("%0t: mismatch expected status=%0d read_value=%h position=%0d count=%0d",
                   $time, want.status, want.read_value, want.position, want.count);
          $display("%0t:          actual   status=%0d read_value=%h position=%0d count=%0d",
                   $time, rsp_if.status, rsp_if.read_value, rsp_if.position, rsp_if.count);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, stall_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

[files.f]
hdl/olt_pkg.sv
hdl/olt_req_if.sv
hdl/olt_rsp_if.sv
hdl/olt_ram.sv
hdl/olt_wrap.sv
hdl/ordered_list_table_core.sv
hdl/olt_checker.sv
dv/ordered_list_table_core_tb.sv
